// ===== design/rrsd_pkg.sv =====
package rrsd_pkg;

  // Field widths of the stream and configuration ports.
  localparam int unsigned PIXEL_W    = 8;
  localparam int unsigned COORD_W    = 12;
  localparam int unsigned MIN_LEN_W  = 13;
  localparam int unsigned GAP_MAX_W  = 12;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned IN_TDATA_W = 8;
  localparam int unsigned OUT_TDATA_W = 40;

  // Default frame geometry.
  localparam int unsigned MAX_WIDTH_DEF  = 4096;
  localparam int unsigned MAX_HEIGHT_DEF = 4096;

  // A pixel at or below this value counts as black.
  localparam logic [PIXEL_W-1:0] BLACK_LIMIT = 8'd128;

  // Register reset values.
  localparam logic [MIN_LEN_W-1:0] MIN_LEN_RST = 13'd10;
  localparam logic [GAP_MAX_W-1:0] GAP_MAX_RST = 12'd2;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_MIN_LEN = 1'b0,
    CFG_GAP_MAX = 1'b1
  } cfg_idx_e;

  // One reported segment.
  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] seg_start;
    logic [COORD_W-1:0] seg_end;
    logic               last;
  } seg_t;

  // Results caused by one pixel, packed from slot zero.
  typedef struct packed {
    logic [1:0] cnt;
    seg_t       seg0;
    seg_t       seg1;
  } res_t;

endpackage

// ===== design/rrsd_core.sv =====
module rrsd_core
  import rrsd_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  logic [PIXEL_W-1:0]   pixel_i,
  input  logic                 eol_i,
  input  logic                 eof_i,
  input  logic [MIN_LEN_W-1:0] min_len_i,
  input  logic [GAP_MAX_W-1:0] gap_max_i,
  output res_t                 res_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned GW = (CW > GAP_MAX_W) ? CW : GAP_MAX_W;
  localparam int unsigned LW = ((CW > MIN_LEN_W) ? CW : MIN_LEN_W) + 2;
  localparam logic [CW-1:0] COL_MAX = CW'(MAX_WIDTH - 1);
  localparam logic [RW-1:0] ROW_MAX = RW'(MAX_HEIGHT - 1);

  // Segment length last - first + 1 reaches the configured minimum.
  function automatic logic len_ok(input logic [CW-1:0] first, input logic [CW-1:0] last,
                                  input logic [MIN_LEN_W-1:0] min_len);
    logic signed [LW-1:0] len;
    len = $signed(LW'(last)) - $signed(LW'(first)) + $signed(LW'(1));
    return len >= $signed(LW'(min_len));
  endfunction

  logic          prev_black_q, prev_black_d;
  logic          run_open_q, run_open_d;
  logic [CW-1:0] run_first_q, run_first_d;
  logic [CW-1:0] run_last_q, run_last_d;
  logic [CW-1:0] column_q, column_d;
  logic [RW-1:0] row_q, row_d;

  logic          black, rise, fall, gap_big;
  logic [CW-1:0] gap, first_mid, last_mid, last_eol;
  logic          open_mid, emit0, emit1;
  seg_t          r0, r1;

  // Edge detection and gap measurement on the current pixel.
  always_comb begin
    black    = pixel_i <= BLACK_LIMIT;
    rise     = !prev_black_q && black;
    fall     = prev_black_q && !black;
    gap      = column_q - run_last_q - CW'(1);
    gap_big  = (run_last_q != '0) && (GW'(gap) > GW'(gap_max_i));
    first_mid = (rise && (gap_big || !run_open_q)) ? column_q : run_first_q;
    open_mid  = run_open_q || rise;
    last_mid  = fall ? (column_q - CW'(1)) : run_last_q;
    last_eol  = black ? column_q : last_mid;
    emit0 = rise && gap_big && len_ok(run_first_q, run_last_q, min_len_i);
    emit1 = eol_i && (last_eol != '0) && len_ok(first_mid, last_eol, min_len_i);
  end

  // Result slots: the gap closure comes first, the row end second.
  always_comb begin
    r0.row       = COORD_W'(row_q);
    r0.seg_start = COORD_W'(run_first_q);
    r0.seg_end   = COORD_W'(run_last_q);
    r0.last      = !emit1;
    r1.row       = COORD_W'(row_q);
    r1.seg_start = COORD_W'(first_mid);
    r1.seg_end   = COORD_W'(last_eol);
    r1.last      = 1'b1;
    res_o.cnt  = {1'b0, emit0} + {1'b0, emit1};
    res_o.seg0 = emit0 ? r0 : r1;
    res_o.seg1 = r1;
  end

  // Next state of the row tracker.
  always_comb begin
    prev_black_d = prev_black_q;
    run_open_d   = run_open_q;
    run_first_d  = run_first_q;
    run_last_d   = run_last_q;
    column_d     = column_q;
    row_d        = row_q;
    if (fire_i) begin
      if (eol_i) begin
        prev_black_d = 1'b0;
        run_open_d   = 1'b0;
        run_first_d  = '0;
        run_last_d   = '0;
        column_d     = '0;
        if (eof_i) begin
          row_d = '0;
        end else if (row_q < ROW_MAX) begin
          row_d = row_q + RW'(1);
        end
      end else begin
        prev_black_d = black;
        run_open_d   = open_mid;
        run_first_d  = first_mid;
        run_last_d   = last_mid;
        if (column_q < COL_MAX) begin
          column_d = column_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_black_q <= 1'b0;
      run_open_q   <= 1'b0;
      run_first_q  <= '0;
      run_last_q   <= '0;
      column_q     <= '0;
      row_q        <= '0;
    end else begin
      prev_black_q <= prev_black_d;
      run_open_q   <= run_open_d;
      run_first_q  <= run_first_d;
      run_last_q   <= run_last_d;
      column_q     <= column_d;
      row_q        <= row_d;
    end
  end

endmodule

// ===== design/rrsd_out_buf.sv =====
module rrsd_out_buf
  import rrsd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic fire_i,
  input  res_t res_i,
  output logic free_o,
  output logic valid_o,
  input  logic ready_i,
  output seg_t seg_o
);

  logic [1:0] cnt_q, cnt_d;
  seg_t       slot0_q, slot0_d;
  seg_t       slot1_q, slot1_d;
  logic       pop;

  // The buffer can take a new pixel's results once it drains this cycle.
  always_comb begin
    pop    = (cnt_q != 2'd0) && ready_i;
    free_o = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop);
  end

  // Load new results, or shift the second slot forward on a transaction.
  always_comb begin
    cnt_d   = cnt_q;
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    if (fire_i) begin
      cnt_d   = res_i.cnt;
      slot0_d = res_i.seg0;
      slot1_d = res_i.seg1;
    end else if (pop) begin
      cnt_d   = cnt_q - 2'd1;
      slot0_d = slot1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

  assign valid_o = cnt_q != 2'd0;
  assign seg_o   = slot0_q;

endmodule

// ===== design/row_run_segment_detector_top.sv =====
// A segment is presented on the segment stream once the pixel that closes it has passed
// the input register and been loaded into the result register.
// Throughput: one pixel per clock while the segment stream is ready; a pixel that closes two
// segments holds the input back, since the result register hands out one segment per clock.
// Reset (rst_ni, asynchronous, active low) clears the row tracker, the row counter and
// the buffers, and loads a minimum length of 10 and a largest bridged gap of 2.
module row_run_segment_detector_top
  import rrsd_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration write port.
  input  logic                   cfg_we_i,
  input  logic [0:0]             cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  // Pixel stream.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // pixel[7:0]
  input  logic                   s_axis_tlast,  // end_of_line
  input  logic                   s_axis_tuser,  // end_of_frame
  // Segment stream.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // row[11:0], seg_start[23:12], seg_end[35:24]
  output logic                   m_axis_tlast   // last
);

  logic [MIN_LEN_W-1:0]  min_len_q;
  logic [GAP_MAX_W-1:0]  gap_max_q;
  logic                  in_valid_q;
  logic [PIXEL_W-1:0]    pixel_q;
  logic                  eol_q, eof_q;
  logic                  fire, free, accept;
  res_t                  res;
  seg_t                  seg;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= MIN_LEN_RST;
      gap_max_q <= GAP_MAX_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MIN_LEN: min_len_q <= cfg_wdata_i;
        CFG_GAP_MAX: gap_max_q <= cfg_wdata_i[GAP_MAX_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register: a pixel moves on to the tracker when the result register has room.
  assign fire          = in_valid_q && free;
  assign s_axis_tready = !in_valid_q || fire;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pixel_q <= s_axis_tdata[PIXEL_W-1:0];
      eol_q   <= s_axis_tlast;
      eof_q   <= s_axis_tuser;
    end
  end

  rrsd_core #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .pixel_i   (pixel_q),
    .eol_i     (eol_q),
    .eof_i     (eof_q),
    .min_len_i (min_len_q),
    .gap_max_i (gap_max_q),
    .res_o     (res)
  );

  rrsd_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .res_i   (res),
    .free_o  (free),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .seg_o   (seg)
  );

  // Pack the segment fields into the output data word.
  assign m_axis_tdata = {(OUT_TDATA_W - 3 * COORD_W)'(0), seg.seg_end, seg.seg_start, seg.row};
  assign m_axis_tlast = seg.last;

endmodule
